### design/clns_pkg.sv
// Shared types, codes and constants of the character LCD nibble sequencer.
`timescale 1ns / 1ps
`default_nettype none

package clns_pkg;

  // Request kinds.
  localparam logic [2:0] KIND_COMMAND   = 3'd0;
  localparam logic [2:0] KIND_CHARACTER = 3'd1;
  localparam logic [2:0] KIND_CURSOR    = 3'd2;
  localparam logic [2:0] KIND_INIT      = 3'd3;
  localparam logic [2:0] KIND_BACKLIGHT = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_INIT = 2'd1;
  localparam logic [1:0] STATUS_BAD_ROW  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_ACTIVE_LOW = 1'b0;
  localparam logic CFG_ROW_BASE   = 1'b1;

  // Display geometry.
  localparam logic [7:0] ROW_COUNT     = 8'd2;
  localparam logic [6:0] ROW_BASE_RST  = 7'd64;

  // Command codes; clear and home need the long execution time.
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  // Waits in microseconds; the EN, nibble and last-write waits already include the 50 us write gap.
  localparam logic [17:0] WAIT_NONE      = 18'd0;
  localparam logic [17:0] WAIT_EN        = 18'd50;
  localparam logic [17:0] WAIT_CMD_LAST  = 18'd170;
  localparam logic [17:0] WAIT_SLOW_LAST = 18'd5050;
  localparam logic [17:0] WAIT_NIB_LONG  = 18'd10050;
  localparam logic [17:0] WAIT_NIB_MID   = 18'd2050;
  localparam logic [17:0] WAIT_POWER_UP  = 18'd200000;
  localparam logic [17:0] WAIT_KNOWN     = 18'd1000;

  // Power-up sequence bounds.
  localparam logic [2:0] INIT_NIB_LAST = 3'd3;
  localparam logic [2:0] INIT_CMD_LAST = 3'd4;
  localparam logic [1:0] PHASE_EN_HIGH = 2'd2;
  localparam logic [1:0] PHASE_LAST    = 2'd3;
  localparam logic [2:0] BYTE_WR_LAST  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERROR,
    ST_BLITE,
    ST_PWRUP,
    ST_KNOWN,
    ST_NIBBLE,
    ST_BYTE
  } state_e;

  // What the datapath puts in the output register.
  typedef enum logic [2:0] {
    RES_ERROR,
    RES_POWER,
    RES_KNOWN,
    RES_NIBBLE,
    RES_BYTE,
    RES_BLITE
  } res_e;

  typedef struct packed {
    logic       accept;
    logic       clr_ready;
    logic       set_ready;
    logic       set_bl;
    logic       emit;
    res_e       res;
    logic [1:0] err_status;
    logic [2:0] cnt;
    logic [2:0] item;
    logic       init_seq;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ready;
    logic row_bad;
    logic out_free;
  } dp_status_t;

  // Setup commands sent after the nibble sequence.
  function automatic logic [7:0] init_cmd_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

  // Wait after the last write of each power-up nibble.
  function automatic logic [17:0] init_nib_wait(input logic [2:0] idx);
    logic [17:0] w;
    unique case (idx)
      3'd0, 3'd1: w = WAIT_NIB_LONG;
      3'd2:       w = WAIT_NIB_MID;
      default:    w = WAIT_CMD_LAST;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/clns_ctrl.sv
// Controller state machine that steps through the writes of each request.
`timescale 1ns / 1ps
`default_nettype none

module clns_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire [2:0]              kind_i,
  input  clns_pkg::dp_status_t   sts_i,
  output clns_pkg::ctrl_cmd_t    cmd_o
);
  import clns_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] item_q, item_d;
  logic       init_q, init_d;
  logic [1:0] err_q, err_d;
  logic       accept;
  logic       go;

  // A new request is taken only between requests.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign go         = sts_i.out_free;

  // Next state and step counters.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    item_d  = item_q;
    init_d  = init_q;
    err_d   = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d  = 3'd0;
          item_d = 3'd0;
          init_d = 1'b0;
          unique case (kind_i) inside
            KIND_COMMAND, KIND_CHARACTER: begin
              if (sts_i.ready) begin
                state_d = ST_BYTE;
              end else begin
                state_d = ST_ERROR;
                err_d   = STATUS_NOT_INIT;
              end
            end
            KIND_CURSOR: begin
              if (!sts_i.ready) begin
                state_d = ST_ERROR;
                err_d   = STATUS_NOT_INIT;
              end else if (sts_i.row_bad) begin
                state_d = ST_ERROR;
                err_d   = STATUS_BAD_ROW;
              end else begin
                state_d = ST_BYTE;
              end
            end
            KIND_INIT: begin
              state_d = ST_PWRUP;
            end
            KIND_BACKLIGHT: begin
              if (sts_i.ready) begin
                state_d = ST_BLITE;
              end else begin
                state_d = ST_ERROR;
                err_d   = STATUS_NOT_INIT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ERROR, ST_BLITE: begin
        if (go) begin
          state_d = ST_IDLE;
        end
      end
      ST_PWRUP: begin
        if (go) begin
          state_d = ST_KNOWN;
        end
      end
      ST_KNOWN: begin
        if (go) begin
          state_d = ST_NIBBLE;
          cnt_d   = 3'd0;
          item_d  = 3'd0;
        end
      end
      ST_NIBBLE: begin
        if (go) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q[1:0] == PHASE_LAST) begin
            cnt_d = 3'd0;
            if (item_q == INIT_NIB_LAST) begin
              state_d = ST_BYTE;
              item_d  = 3'd0;
              init_d  = 1'b1;
            end else begin
              item_d = item_q + 3'd1;
            end
          end
        end
      end
      ST_BYTE: begin
        if (go) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == BYTE_WR_LAST) begin
            if (init_q && (item_q != INIT_CMD_LAST)) begin
              item_d = item_q + 3'd1;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o            = '0;
    cmd_o.res        = RES_ERROR;
    cmd_o.accept     = accept;
    cmd_o.clr_ready  = accept && (kind_i == KIND_INIT);
    cmd_o.set_bl     = accept && (kind_i == KIND_BACKLIGHT);
    cmd_o.err_status = err_q;
    cmd_o.cnt        = cnt_q;
    cmd_o.item       = item_q;
    cmd_o.init_seq   = init_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.emit = 1'b0;
      end
      ST_ERROR: begin
        cmd_o.emit = go;
        cmd_o.res  = RES_ERROR;
        cmd_o.last = 1'b1;
      end
      ST_BLITE: begin
        cmd_o.emit = go;
        cmd_o.res  = RES_BLITE;
        cmd_o.last = 1'b1;
      end
      ST_PWRUP: begin
        cmd_o.emit = go;
        cmd_o.res  = RES_POWER;
      end
      ST_KNOWN: begin
        cmd_o.emit = go;
        cmd_o.res  = RES_KNOWN;
      end
      ST_NIBBLE: begin
        cmd_o.emit = go;
        cmd_o.res  = RES_NIBBLE;
      end
      ST_BYTE: begin
        cmd_o.emit = go;
        cmd_o.res  = RES_BYTE;
        cmd_o.last = (cnt_q == BYTE_WR_LAST) && (!init_q || (item_q == INIT_CMD_LAST));
        cmd_o.set_ready = go && (cnt_q == BYTE_WR_LAST) && init_q &&
                          (item_q == INIT_CMD_LAST);
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 3'd0;
      item_q  <= 3'd0;
      init_q  <= 1'b0;
      err_q   <= STATUS_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      item_q  <= item_d;
      init_q  <= init_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

### design/clns_dp.sv
// Datapath: request capture, flags, configuration and the result register.
`timescale 1ns / 1ps
`default_nettype none

module clns_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_valid_i,
  input  wire                   cfg_index_i,
  input  wire [6:0]             cfg_data_i,
  input  wire [2:0]             kind_i,
  input  wire [7:0]             value_byte_i,
  input  wire [7:0]             column_i,
  input  wire [7:0]             row_number_i,
  input  wire                   light_on_i,
  input  clns_pkg::ctrl_cmd_t   cmd_i,
  output clns_pkg::dp_status_t  sts_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [7:0]            expander_byte_o,
  output logic                  write_valid_o,
  output logic [17:0]           wait_us_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);
  import clns_pkg::*;

  logic        active_low_q;
  logic [6:0]  row_base_q;
  logic        ready_q;
  logic        bl_flag_q;
  logic [7:0]  req_byte_q;
  logic        req_rs_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_wv_q;
  logic [17:0] out_wait_q;
  logic [1:0]  out_status_q;
  logic        out_last_q;

  logic [7:0]  cursor_addr;
  logic [7:0]  req_byte_d;
  logic        bl_bit;
  logic [7:0]  cur_byte;
  logic        cur_rs;
  logic [3:0]  nib;
  logic        en_bit;
  logic [7:0]  res_byte;
  logic        res_wv;
  logic [17:0] res_wait;
  logic [1:0]  res_status;

  // Status toward the controller.
  assign sts_o.ready    = ready_q;
  assign sts_o.row_bad  = (row_number_i >= ROW_COUNT);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Cursor command: row zero starts at address zero.
  assign cursor_addr = (row_number_i == 8'd0) ? column_i : column_i + {1'b0, row_base_q};
  assign req_byte_d  = (kind_i == KIND_CURSOR) ? (CMD_SET_DDRAM | cursor_addr) : value_byte_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= 1'b0;
      row_base_q   <= ROW_BASE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ACTIVE_LOW: active_low_q <= cfg_data_i[0];
        CFG_ROW_BASE:   row_base_q   <= cfg_data_i;
        default:        row_base_q   <= row_base_q;
      endcase
    end
  end

  // Initialized and backlight flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   <= 1'b0;
      bl_flag_q <= 1'b1;
    end else begin
      if (cmd_i.clr_ready) begin
        ready_q <= 1'b0;
      end else if (cmd_i.set_ready) begin
        ready_q <= 1'b1;
      end
      if (cmd_i.set_bl) begin
        bl_flag_q <= light_on_i;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_byte_q <= req_byte_d;
      req_rs_q   <= (kind_i == KIND_CHARACTER);
    end
  end

  // Expander byte and wait for the current step.
  assign bl_bit   = bl_flag_q ^ active_low_q;
  assign cur_byte = cmd_i.init_seq ? init_cmd_byte(cmd_i.item) : req_byte_q;
  assign cur_rs   = cmd_i.init_seq ? 1'b0 : req_rs_q;
  assign en_bit   = (cmd_i.cnt[1:0] == PHASE_EN_HIGH);

  always_comb begin
    nib        = 4'h0;
    res_byte   = 8'h00;
    res_wv     = 1'b1;
    res_wait   = WAIT_EN;
    res_status = STATUS_OK;
    case (cmd_i.res)
      RES_ERROR: begin
        res_wv     = 1'b0;
        res_wait   = WAIT_NONE;
        res_status = cmd_i.err_status;
      end
      RES_POWER: begin
        res_wv   = 1'b0;
        res_wait = WAIT_POWER_UP;
      end
      RES_KNOWN: begin
        res_byte = {4'h0, bl_bit, 3'b000};
        res_wait = WAIT_KNOWN;
      end
      RES_BLITE: begin
        res_byte = {4'h0, bl_bit, 3'b000};
        res_wait = WAIT_NONE;
      end
      RES_NIBBLE: begin
        nib      = (cmd_i.item == INIT_NIB_LAST) ? 4'h2 : 4'h3;
        res_byte = {nib, bl_bit, en_bit, 1'b0, 1'b0};
        if (cmd_i.cnt[1:0] == PHASE_LAST) begin
          res_wait = init_nib_wait(cmd_i.item);
        end
      end
      RES_BYTE: begin
        nib      = cmd_i.cnt[2] ? cur_byte[3:0] : cur_byte[7:4];
        res_byte = {nib, bl_bit, en_bit, 1'b0, cur_rs};
        if (cmd_i.cnt == BYTE_WR_LAST) begin
          if (!cur_rs && ((cur_byte == CMD_CLEAR) || (cur_byte == CMD_HOME))) begin
            res_wait = WAIT_SLOW_LAST;
          end else begin
            res_wait = WAIT_CMD_LAST;
          end
        end
      end
      default: begin
        res_wv = 1'b0;
      end
    endcase
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q   <= res_byte;
      out_wv_q     <= res_wv;
      out_wait_q   <= res_wait;
      out_status_q <= res_status;
      out_last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign expander_byte_o = out_byte_q;
  assign write_valid_o   = out_wv_q;
  assign wait_us_o       = out_wait_q;
  assign status_o        = out_status_q;
  assign last_o          = out_last_q;

  // A new result never overwrites one that is still waiting.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending result");

  // Error results close their request.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (cmd_i.res == RES_ERROR)) |-> cmd_i.last)
    else $error("error result without last");

  // The end of power-up leaves the display initialized.
  a_ready_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_ready |=> ready_q)
    else $error("ready flag not set after power-up");

  // Wait-only and error results carry a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_wv_q) |-> (out_byte_q == 8'h00))
    else $error("non-write result carries a byte");

endmodule

`default_nettype wire

### design/char_lcd_nibble_sequencer_unit.sv
// Top level of the character LCD nibble sequencer.
// The request is first registered in the controller state; each result is then loaded
// into the output register when the output is free. Throughput: one result per cycle
// while the output is not stalled; the controller walks the expander writes of a request
// in order and takes a new request only after the last write of the one before is loaded.
// Reset: asynchronous, active low; not initialized, backlight on, row base 64.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [6:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  kind_i,
  input  wire  [7:0]  value_byte_i,
  input  wire  [7:0]  column_i,
  input  wire  [7:0]  row_number_i,
  input  wire         light_on_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  expander_byte_o,
  output logic        write_valid_o,
  output logic [17:0] wait_us_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import clns_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  clns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  clns_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .value_byte_i    (value_byte_i),
    .column_i        (column_i),
    .row_number_i    (row_number_i),
    .light_on_i      (light_on_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .expander_byte_o (expander_byte_o),
    .write_valid_o   (write_valid_o),
    .wait_us_o       (wait_us_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

### tb/char_lcd_nibble_sequencer_unit_tb.sv
// Self-checking testbench of the character LCD nibble sequencer with a write scoreboard.
`timescale 1ns / 1ps

import clns_pkg::*;

// One expander write as it leaves the sequencer.
typedef struct {
  logic [7:0]  xbyte;
  logic        wr;
  logic [17:0] delay;
  logic [1:0]  status;
  logic        last;
} lcd_write_t;

// Predicts the expander writes of each request and checks them in order.
class LcdWriteScoreboard;
  // Expander bit positions.
  localparam logic [7:0] EXP_RS = 8'h01;
  localparam logic [7:0] EXP_EN = 8'h04;
  localparam logic [7:0] EXP_BL = 8'h08;
  // Waits in microseconds.
  localparam logic [17:0] WRITE_GAP     = 18'd50;
  localparam logic [17:0] EXTRA_CMD     = 18'd120;
  localparam logic [17:0] EXTRA_SLOW    = 18'd5000;
  localparam logic [17:0] EXTRA_WAKE    = 18'd10000;
  localparam logic [17:0] EXTRA_WAKE_3  = 18'd2000;
  localparam logic [17:0] POWER_UP_WAIT = 18'd200000;
  localparam logic [17:0] KNOWN_WAIT    = 18'd1000;
  // Power-up nibbles and setup commands.
  localparam logic [3:0] NIB_WAKE          = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT      = 4'h2;
  localparam logic [7:0] CMD_FUNCTION_SET  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_OFF   = 8'h08;
  localparam logic [7:0] CMD_ENTRY_MODE    = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0C;

  logic       active_low;
  logic [6:0] row_base;
  logic       display_ready;
  logic       light_flag;
  int         errors;
  int         result_no;
  lcd_write_t expected_q[$];
  lcd_write_t burst_q[$];

  function new();
    active_low    = 1'b0;
    row_base      = ROW_BASE_RST;
    display_ready = 1'b0;
    light_flag    = 1'b1;
    errors        = 0;
    result_no     = 0;
  endfunction

  function void set_register(logic idx, logic [6:0] data);
    if (idx == CFG_ACTIVE_LOW) begin
      active_low = data[0];
    end else begin
      row_base = data;
    end
  endfunction

  function logic [7:0] light_bits();
    return (light_flag ^ active_low) ? EXP_BL : 8'h00;
  endfunction

  function void add_write(logic [7:0] xbyte, logic wr, logic [17:0] delay, logic [1:0] status);
    lcd_write_t w;
    w.xbyte  = xbyte;
    w.wr     = wr;
    w.delay  = delay;
    w.status = status;
    w.last   = 1'b0;
    burst_q.push_back(w);
  endfunction

  // Extra execution time lands on the final write of the byte.
  function void extend_wait(logic [17:0] extra);
    lcd_write_t w;
    w = burst_q.pop_back();
    w.delay = w.delay + extra;
    burst_q.push_back(w);
  endfunction

  // A nibble is a setup write, EN low, EN high, EN low.
  function void nibble_writes(logic [3:0] nib, logic rs);
    logic [7:0] setup;
    setup = {nib, 4'h0} | light_bits() | (rs ? EXP_RS : 8'h00);
    add_write(setup, 1'b1, WRITE_GAP, STATUS_OK);
    add_write(setup, 1'b1, WRITE_GAP, STATUS_OK);
    add_write(setup | EXP_EN, 1'b1, WRITE_GAP, STATUS_OK);
    add_write(setup, 1'b1, WRITE_GAP, STATUS_OK);
  endfunction

  function void byte_writes(logic [7:0] value, logic rs);
    nibble_writes(value[7:4], rs);
    nibble_writes(value[3:0], rs);
  endfunction

  function void command_writes(logic [7:0] code);
    byte_writes(code, 1'b0);
    extend_wait((code == CMD_CLEAR || code == CMD_HOME) ? EXTRA_SLOW : EXTRA_CMD);
  endfunction

  // Work out every write that an accepted request causes.
  function void note_request(logic [2:0] kind, logic [7:0] value, logic [7:0] column,
                             logic [7:0] row, logic light_on);
    logic [7:0] addr;
    burst_q.delete();
    case (kind)
      KIND_COMMAND: begin
        if (!display_ready) add_write(8'h00, 1'b0, 18'd0, STATUS_NOT_INIT);
        else command_writes(value);
      end
      KIND_CHARACTER: begin
        if (!display_ready) begin
          add_write(8'h00, 1'b0, 18'd0, STATUS_NOT_INIT);
        end else begin
          byte_writes(value, 1'b1);
          extend_wait(EXTRA_CMD);
        end
      end
      KIND_CURSOR: begin
        if (!display_ready) begin
          add_write(8'h00, 1'b0, 18'd0, STATUS_NOT_INIT);
        end else if (row >= ROW_COUNT) begin
          add_write(8'h00, 1'b0, 18'd0, STATUS_BAD_ROW);
        end else begin
          addr = ((row == 8'h00) ? 8'h00 : {1'b0, row_base}) + column;
          command_writes(CMD_SET_DDRAM | addr);
        end
      end
      KIND_INIT: begin
        display_ready = 1'b0;
        add_write(8'h00, 1'b0, POWER_UP_WAIT, STATUS_OK);
        add_write(light_bits(), 1'b1, KNOWN_WAIT, STATUS_OK);
        nibble_writes(NIB_WAKE, 1'b0);
        extend_wait(EXTRA_WAKE);
        nibble_writes(NIB_WAKE, 1'b0);
        extend_wait(EXTRA_WAKE);
        nibble_writes(NIB_WAKE, 1'b0);
        extend_wait(EXTRA_WAKE_3);
        nibble_writes(NIB_FOUR_BIT, 1'b0);
        extend_wait(EXTRA_CMD);
        command_writes(CMD_FUNCTION_SET);
        command_writes(CMD_DISPLAY_OFF);
        command_writes(CMD_CLEAR);
        command_writes(CMD_ENTRY_MODE);
        command_writes(CMD_DISPLAY_ON);
        display_ready = 1'b1;
      end
      KIND_BACKLIGHT: begin
        light_flag = light_on;
        if (!display_ready) add_write(8'h00, 1'b0, 18'd0, STATUS_NOT_INIT);
        else add_write(light_bits(), 1'b1, 18'd0, STATUS_OK);
      end
      default: begin
        // Unused kinds are dropped by the block.
      end
    endcase
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size() - 1].last = 1'b1;
      foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
    end
  endfunction

  function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: write %0d %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, result_no, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare an accepted write with the oldest one predicted.
  function void check_result(logic [7:0] xbyte, logic wr, logic [17:0] delay,
                             logic [1:0] status, logic last);
    lcd_write_t e;
    result_no++;
    if (expected_q.size() == 0) begin
      $display("%0t: write %0d not predicted, expected none, actual byte 0x%0h status %0d",
               $time, result_no, xbyte, status);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    check_field("expander_byte", e.xbyte, xbyte);
    check_field("write_valid", e.wr, wr);
    check_field("wait_us", e.delay, delay);
    check_field("status", e.status, status);
    check_field("last", e.last, last);
  endfunction
endclass

module char_lcd_nibble_sequencer_unit_tb;
  localparam int LIMIT_CYCLES     = 200000;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 80;
  localparam int RESET_CYCLES     = 11;
  localparam int RANDOM_PER_PHASE = 30;
  localparam int PHASE_COUNT      = 5;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [6:0]  cfg_data_i = 7'h00;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = 3'd0;
  logic [7:0]  value_byte_i = 8'h00;
  logic [7:0]  column_i = 8'h00;
  logic [7:0]  row_number_i = 8'h00;
  logic        light_on_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  expander_byte_o;
  logic        write_valid_o;
  logic [17:0] wait_us_o;
  logic [1:0]  status_o;
  logic        last_o;

  logic send_idle_on = 1'b0;
  logic recv_idle_on = 1'b0;
  logic hold_go = 1'b0;
  int   cycle_count;

  LcdWriteScoreboard sb;

  char_lcd_nibble_sequencer_unit u_top (.*);

  // Free-running 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note accepted requests and check accepted writes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_request(kind_i, value_byte_i, column_i, row_number_i, light_on_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(expander_byte_o, write_valid_o, wait_us_o, status_o, last_o);
    end
  end

  // Output side: random stall bursts, and one long hold-off on request.
  initial begin : receiver
    int burst;
    int hold_count;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall_i = 1'b1;
        for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk_i);
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        burst = $urandom_range(1, 6);
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Give up if the run hangs.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offer one request and hold it until accepted; valid stays high afterward.
  task automatic send_request(logic [2:0] kind, logic [7:0] value, logic [7:0] column,
                              logic [7:0] row, logic light_on);
    int gap;
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i       = kind;
    value_byte_i = value;
    column_i     = column;
    row_number_i = row;
    light_on_i   = light_on;
    in_valid_i   = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop offering and let every predicted write drain, plus the tail of the sequence.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write both registers back to back while the block is idle.
  task automatic write_config(logic [6:0] polarity, logic [6:0] base);
    cfg_index_i = CFG_ACTIVE_LOW;
    cfg_data_i  = polarity;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(CFG_ACTIVE_LOW, polarity);
    @(negedge clk_i);
    cfg_index_i = CFG_ROW_BASE;
    cfg_data_i  = base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(CFG_ROW_BASE, base);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One random request; mostly valid work, some cursor rows out of range, a little noise.
  task automatic random_request(inout int counted);
    int         pick;
    logic [7:0] value;
    logic [7:0] row;
    logic [2:0] junk_kind;
    pick  = $urandom_range(0, 99);
    value = $urandom_range(0, 255);
    if ($urandom_range(0, 4) == 0) row = $urandom_range(0, 255);
    else row = $urandom_range(0, ROW_COUNT - 1);
    if (pick < 5) begin
      junk_kind = $urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI);
      send_request(junk_kind, value, $urandom_range(0, 255), row, $urandom_range(0, 1));
    end else begin
      counted++;
      if (pick < 10) begin
        send_request(KIND_INIT, value, $urandom_range(0, 255), row, $urandom_range(0, 1));
      end else if (pick < 35) begin
        if ($urandom_range(0, 9) == 0) value = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
        send_request(KIND_COMMAND, value, $urandom_range(0, 255), row, $urandom_range(0, 1));
      end else if (pick < 60) begin
        send_request(KIND_CHARACTER, value, $urandom_range(0, 255), row, $urandom_range(0, 1));
      end else if (pick < 85) begin
        send_request(KIND_CURSOR, value, $urandom_range(0, 255), row, $urandom_range(0, 1));
      end else begin
        send_request(KIND_BACKLIGHT, value, $urandom_range(0, 255), row, $urandom_range(0, 1));
      end
    end
  endtask

  initial begin : stimulus
    int         phase;
    int         counted;
    logic [2:0] junk_kind;
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // Everything but initialize is refused before the display is set up.
    send_request(KIND_COMMAND, CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    send_request(KIND_CHARACTER, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_request(KIND_CURSOR, 8'h00, 8'hFF, 8'hFF, 1'b0);
    send_request(KIND_BACKLIGHT, 8'h00, 8'h00, 8'h00, 1'b0);
    junk_kind = KIND_UNUSED_LO;
    repeat (3) begin
      send_request(junk_kind, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      junk_kind++;
    end

    // Power-up with the light off, then the corner cases of each kind.
    send_request(KIND_INIT, 8'h00, 8'h00, 8'h00, 1'b0);
    send_request(KIND_BACKLIGHT, 8'h00, 8'h00, 8'h00, 1'b1);
    send_request(KIND_COMMAND, CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    send_request(KIND_COMMAND, CMD_HOME, 8'h00, 8'h00, 1'b0);
    send_request(KIND_COMMAND, 8'h00, 8'h00, 8'h00, 1'b0);
    send_request(KIND_COMMAND, 8'hFF, 8'h00, 8'h00, 1'b0);
    send_request(KIND_CHARACTER, 8'h00, 8'h00, 8'h00, 1'b0);
    send_request(KIND_CHARACTER, 8'hFF, 8'h00, 8'h00, 1'b0);
    send_request(KIND_CURSOR, 8'h00, 8'h00, 8'h00, 1'b0);
    send_request(KIND_CURSOR, 8'h00, 8'hFF, 8'h01, 1'b0);
    send_request(KIND_CURSOR, 8'h00, 8'h07, ROW_COUNT, 1'b0);
    send_request(KIND_CURSOR, 8'h00, 8'h00, 8'hFF, 1'b0);
    send_request(KIND_BACKLIGHT, 8'h00, 8'h00, 8'h00, 1'b0);
    // Initialize again while already running.
    send_request(KIND_INIT, 8'h00, 8'h00, 8'h00, 1'b0);
    send_request(KIND_BACKLIGHT, 8'h00, 8'h00, 8'h00, 1'b1);

    // Random phases, each under its own register setting.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      send_idle_on = 1'b1;
      case (phase)
        0: write_config(7'h00, ROW_BASE_RST);
        1: write_config(7'h7F, 7'h7F);
        2: begin
          // Long output hold-off while requests keep coming.
          write_config(7'h00, 7'h00);
          send_idle_on = 1'b0;
          hold_go = 1'b1;
        end
        3: write_config($urandom_range(0, 127), $urandom_range(0, 127));
        default: begin
          write_config($urandom_range(0, 127), $urandom_range(0, 127));
          send_idle_on = 1'b0;
          recv_idle_on = 1'b0;
        end
      endcase
      counted = 0;
      while (counted < RANDOM_PER_PHASE) random_request(counted);
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
